// ----- rtl/idfs_pkg.sv -----
`timescale 1ns / 1ps

package idfs_pkg;

    localparam int FREE_DEPTH = 1024;
    localparam int ID_W       = 32;
    localparam int ADDR_W     = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

endpackage

// ----- rtl/id_allocator_free_stack.sv -----
`timescale 1ns / 1ps

// Identifier allocator with a LIFO free stack held in one single-port-read
// RAM of FREE_DEPTH entries. A free, and an allocate that takes a fresh id
// (stack empty), complete with the result registered at the accept edge,
// and a new item can be taken every cycle. An allocate that pops the stack
// waits for the registered RAM read; s_ready is low during the read. Fresh
// ids start at 1 and skip 0 on wrap. A free into a full stack is dropped
// and reported with status 1. An item is taken while the previous result
// waits only if m_ready is high in that cycle; results leave through a
// single output register.
module id_allocator_free_stack (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_opcode,
    input  logic [idfs_pkg::ID_W-1:0] s_freed_id,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [idfs_pkg::ID_W-1:0] m_granted_id,
    output logic                    m_status
);

    import idfs_pkg::*;

    logic              busy_reg, busy_next;
    logic              m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]   fresh_reg, fresh_next;
    logic [ID_W-1:0]   granted_reg, granted_next;
    logic              status_reg, status_next;

    logic              out_free;
    logic              accept;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ID_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]  count_dec;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !busy_reg && out_free;
    assign accept    = s_valid && s_ready;
    assign count_dec = count_reg - CNT_W'(1);
    assign ram_waddr = count_reg[ADDR_W-1:0];
    assign ram_raddr = count_dec[ADDR_W-1:0];

    idfs_ram #(
        .WIDTH(ID_W),
        .DEPTH(FREE_DEPTH)
    ) u_stack_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_freed_id),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg && !m_ready;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        priority if (busy_reg && out_free) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            granted_next = ram_rdata;
            status_next  = STATUS_DONE;
        end else if (accept) begin
            unique case (s_opcode)
                OP_ALLOC: begin
                    if (count_reg != '0) begin
                        ram_re     = 1'b1;
                        count_next = count_dec;
                        busy_next  = 1'b1;
                    end else begin
                        m_valid_next = 1'b1;
                        granted_next = fresh_reg;
                        status_next  = STATUS_DONE;
                        fresh_next   = (fresh_reg == '1) ? ID_W'(1) : fresh_reg + ID_W'(1);
                    end
                end
                OP_FREE: begin
                    m_valid_next = 1'b1;
                    granted_next = '0;
                    if (count_reg < CNT_W'(FREE_DEPTH)) begin
                        ram_we      = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = STATUS_DONE;
                    end else begin
                        status_next = STATUS_DROPPED;
                    end
                end
                default: begin
                    m_valid_next = m_valid_reg && !m_ready;
                end
            endcase
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            fresh_reg   <= ID_W'(1);
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_granted_id = granted_reg;
    assign m_status     = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FREE_DEPTH))
        else $error("free count above stack depth");

    a_fresh_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg != '0)
        else $error("fresh id is zero");

    a_pop_goes_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_opcode == OP_ALLOC && count_reg != '0) |=> busy_reg)
        else $error("pop did not wait for stack read");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready)
        else $error("item taken during stack read");

    a_drop_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_opcode == OP_FREE && count_reg == CNT_W'(FREE_DEPTH))
        |=> (count_reg == $past(count_reg) && m_status == STATUS_DROPPED))
        else $error("dropped free changed the stack");
`endif

endmodule

// ----- rtl/idfs_ram.sv -----
`timescale 1ns / 1ps

module idfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/sv/id_allocator_free_stack_tb.sv -----
`timescale 1ns / 1ps

module id_allocator_free_stack_tb;
    import idfs_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            status;
    } grant_t;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    logic            s_opcode;
    logic [ID_W-1:0] s_freed_id;
    logic            m_valid;
    logic            m_ready;
    logic [ID_W-1:0] m_granted_id;
    logic            m_status;

    logic [ID_W-1:0] pool_stack [FREE_DEPTH];
    int unsigned     pool_count;
    logic [ID_W-1:0] next_fresh;
    grant_t          pending_grants[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned stall_cycles;
    int unsigned error_count;
    int unsigned fresh_count;
    int unsigned popped_count;
    int unsigned freed_count;
    int unsigned dropped_count;
    logic [ID_W-1:0] last_freed;

    id_allocator_free_stack dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_freed_id  (s_freed_id),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_granted_id(m_granted_id),
        .m_status    (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic grant_t predict_grant(logic op, logic [ID_W-1:0] id);
        grant_t g;
        g.granted_id = '0;
        g.status     = STATUS_DONE;
        if (op == OP_ALLOC) begin
            if (pool_count > 0) begin
                pool_count--;
                g.granted_id = pool_stack[pool_count];
                popped_count++;
            end else begin
                g.granted_id = next_fresh;
                next_fresh   = next_fresh + 1;
                if (next_fresh == '0) begin
                    next_fresh = 1;
                end
                fresh_count++;
            end
        end else if (pool_count < FREE_DEPTH) begin
            pool_stack[pool_count] = id;
            pool_count++;
            freed_count++;
        end else begin
            g.status = STATUS_DROPPED;
            dropped_count++;
        end
        return g;
    endfunction

    // check results against the oldest prediction, then predict the new item
    always @(posedge aclk) begin
        grant_t exp_g;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_grants.size() == 0) begin
                    $error("result with no pending request: granted_id %h status %b",
                           m_granted_id, m_status);
                    error_count++;
                end else begin
                    exp_g = pending_grants.pop_front();
                    if (m_granted_id !== exp_g.granted_id) begin
                        $error("granted_id mismatch: expected %h, actual %h",
                               exp_g.granted_id, m_granted_id);
                        error_count++;
                    end
                    if (m_status !== exp_g.status) begin
                        $error("status mismatch: expected %b, actual %b",
                               exp_g.status, m_status);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_grants.push_back(predict_grant(s_opcode, s_freed_id));
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic send_item(input logic op, input logic [ID_W-1:0] id);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_freed_id <= id;
        if (op == OP_FREE) begin
            last_freed = id;
        end
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return last_freed;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_cases();
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '1);
        send_item(OP_ALLOC, 32'hA5A5_A5A5);
        send_item(OP_FREE, '0);
        send_item(OP_FREE, '1);
        send_item(OP_FREE, 32'h0000_0007);
        send_item(OP_FREE, 32'h0000_0002);
        send_item(OP_FREE, 32'h0000_0002);
        repeat (5) send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '1);
        send_item(OP_FREE, 32'h0000_0001);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, 32'hAAAA_AAAA);
        send_item(OP_FREE, 32'h5555_5555);
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '0);
    endtask

    task automatic test_random_near_empty(input int unsigned n);
        repeat (n) send_item(logic'($urandom_range(1)), pick_id());
    endtask

    // stack ends full whatever it held before, so the last frees are dropped
    task automatic test_fill_and_overflow();
        for (int i = 0; i < FREE_DEPTH + 4; i++) begin
            if (i == 100) begin
                hold_req = 1'b1;
            end
            send_item(OP_FREE, pick_id());
        end
    endtask

    task automatic test_random_near_full(input int unsigned n);
        repeat (n) begin
            if ($urandom_range(1) == 0) begin
                send_item(OP_ALLOC, $urandom);
            end else begin
                send_item(OP_FREE, pick_id());
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_opcode      = OP_ALLOC;
        s_freed_id    = '0;
        hold_req      = 1'b0;
        stall_cycles  = 0;
        error_count   = 0;
        fresh_count   = 0;
        popped_count  = 0;
        freed_count   = 0;
        dropped_count = 0;
        last_freed    = '0;
        pool_count    = 0;
        next_fresh    = 1;
        set_idling(28, 83);
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_random_near_empty(60);
        set_idling(83, 28);
        test_fill_and_overflow();
        set_idling(0, 0);
        test_random_near_full(60);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_grants.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_grants.size() != 0) begin
            $error("%0d results never arrived", pending_grants.size());
            error_count++;
        end

        $display("Covered %0d allocations (%0d fresh, %0d from the free stack)",
                 fresh_count + popped_count, fresh_count, popped_count);
        $display("and %0d frees, %0d of them dropped on a full stack, under three idle mixes.",
                 freed_count + dropped_count, dropped_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
